// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication that must hold at every enabled clock edge
`define KSTM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("kstm assertion failed");

// implication that must hold on the clock edge after the trigger
`define KSTM_ASSERT_NEXT(lbl, clk, rstn, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (prop)) \
        else $error("kstm assertion failed");

`endif

// ===== rtl/kstm_pkg.sv =====
`timescale 1ns / 1ps

package kstm_pkg;

    // default sizes
    localparam int unsigned NODE_COUNT_DEF   = 64;
    localparam int unsigned ALPHABET_DEF     = 256;
    localparam int unsigned ACTION_COUNT_DEF = 256;

    // request opcodes
    typedef enum logic [0:0] {
        OP_FEED = 1'b0,
        OP_BIND = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        STS_MISMATCH  = 3'd0,
        STS_PARTIAL   = 3'd1,
        STS_MATCH     = 3'd2,
        STS_CONTINUE  = 3'd3,
        STS_DONE      = 3'd4,
        STS_CONFLICT  = 3'd5,
        STS_EXHAUSTED = 3'd6
    } t_status;

    // table entry kinds
    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_INNER = 2'd1,
        KIND_FINAL = 2'd2
    } t_kind;

    // request payload
    typedef struct packed {
        t_op         op;
        logic [7:0]  token;
        logic        path_end;
        logic [7:0]  action_id;
    } t_in_item;

    // result payload
    typedef struct packed {
        t_status     status;
        logic [7:0]  matched_action;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic clr_we;
        logic load;
        logic exec;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
    } t_sts;

endpackage

// ===== rtl/key_sequence_trie_matcher_top.sv =====
`timescale 1ns / 1ps
// key sequence trie matcher
// requests: drive i_req and raise start; a request is taken at a rising edge
//   where start is high and busy is low. op feed steps the matcher by one
//   token, op bind adds one byte of a key path (path_end marks the last one).
// results: one per request on o_result, shown for exactly one cycle with
//   o_valid high; the receiver cannot stall, so it must take it then.
// the table slot is read into a register when the request is taken; the
//   decision, table write and result register follow in the exec state.
// busy is high for the cycle after a request is taken, so each request is
//   decided before the next is taken; a new one may be taken while o_valid is high.
// reset: i_rst_n is synchronous, active low. after release the node table is
//   cleared one entry per cycle, all NODE_COUNT*ALPHABET entries, and busy
//   stays high until that pass ends.
// feed and bind keep separate positions in the trie and may interleave.

module key_sequence_trie_matcher_top
    import kstm_pkg::*;
#(
    parameter int unsigned NODE_COUNT   = NODE_COUNT_DEF,
    parameter int unsigned ALPHABET     = ALPHABET_DEF,
    parameter int unsigned ACTION_COUNT = ACTION_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_req,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    kstm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // table and step logic
    kstm_dp #(
        .NODE_COUNT   (NODE_COUNT),
        .ALPHABET     (ALPHABET),
        .ACTION_COUNT (ACTION_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

// ===== rtl/kstm_ctrl.sv =====
`timescale 1ns / 1ps

module kstm_ctrl
    import kstm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_valid
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (start) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EXEC);
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd.clr_we = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.exec   = (r_state == S_EXEC);
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== rtl/kstm_dp.sv =====
`timescale 1ns / 1ps

module kstm_dp
    import kstm_pkg::*;
#(
    parameter int unsigned NODE_COUNT   = NODE_COUNT_DEF,
    parameter int unsigned ALPHABET     = ALPHABET_DEF,
    parameter int unsigned ACTION_COUNT = ACTION_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_req,
    output t_sts      o_sts,
    output t_out_item o_result
);

    localparam int unsigned DEPTH   = NODE_COUNT * ALPHABET;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned NODE_W  = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned FREE_W  = $clog2(NODE_COUNT + 1);
    localparam int unsigned ACT_W   = (ACTION_COUNT >= 256) ? 8 : $clog2(ACTION_COUNT);
    localparam int unsigned DATA_W  = (NODE_W > ACT_W) ? NODE_W : ACT_W;
    localparam int unsigned ENT_W   = 2 + DATA_W;
    localparam int unsigned ACT_MAX = ACTION_COUNT - 1;

    // trie table: kind in the top two bits, child node or action below
    logic [ENT_W-1:0] mem [DEPTH];

    logic [ENT_W-1:0]  r_rdata;
    logic [ADDR_W-1:0] r_addr;
    t_in_item          r_item;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [NODE_W-1:0] r_match_node;
    logic [NODE_W-1:0] r_bind_node;
    logic [FREE_W-1:0] r_free_node;
    logic              r_skip;
    t_out_item         r_result;

    logic [NODE_W-1:0] n_match_node;
    logic [NODE_W-1:0] n_bind_node;
    logic [FREE_W-1:0] n_free_node;
    logic              n_skip;
    t_out_item         n_result;

    logic [NODE_W-1:0] rd_node;
    logic [ADDR_W-1:0] rd_addr;
    t_kind             kind;
    logic [DATA_W-1:0] data;
    logic              tok_ok;
    logic [31:0]       act_ext;
    logic [ACT_W-1:0]  act_clamp;
    logic              wr_en;
    logic [ENT_W-1:0]  wr_data;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;

    // slot address of the incoming request
    assign rd_node = (i_req.op == OP_BIND) ? r_bind_node : r_match_node;
    assign rd_addr = ADDR_W'(32'(rd_node) * 32'(ALPHABET) + 32'(i_req.token));

    assign kind   = t_kind'(r_rdata[ENT_W-1 -: 2]);
    assign data   = r_rdata[DATA_W-1:0];
    assign tok_ok = (32'(r_item.token) < 32'(ALPHABET));

    // action clamped into range
    assign act_ext   = 32'(r_item.action_id);
    assign act_clamp = (act_ext > 32'(ACT_MAX)) ? ACT_W'(ACT_MAX) : ACT_W'(act_ext);

    // step decision
    always_comb begin
        n_match_node = r_match_node;
        n_bind_node  = r_bind_node;
        n_free_node  = r_free_node;
        n_skip       = r_skip;
        n_result     = '{status: STS_MISMATCH, matched_action: 8'd0};
        wr_en        = 1'b0;
        wr_data      = '0;
        if (r_item.op == OP_FEED) begin
            n_match_node = '0;
            if (tok_ok) begin
                case (kind)
                    KIND_INNER: begin
                        n_match_node    = data[NODE_W-1:0];
                        n_result.status = STS_PARTIAL;
                    end
                    KIND_FINAL: begin
                        n_result.status         = STS_MATCH;
                        n_result.matched_action = 8'(data[ACT_W-1:0]);
                    end
                    default: n_result.status = STS_MISMATCH;
                endcase
            end
        end else if (r_skip) begin
            n_result.status = STS_CONFLICT;
            if (r_item.path_end) begin
                n_skip      = 1'b0;
                n_bind_node = '0;
            end
        end else if (!tok_ok) begin
            n_result.status = STS_CONFLICT;
            n_bind_node     = '0;
            n_skip          = !r_item.path_end;
        end else if (r_item.path_end) begin
            n_bind_node = '0;
            if (kind == KIND_INNER) begin
                n_result.status = STS_CONFLICT;
            end else begin
                wr_en           = 1'b1;
                wr_data         = {KIND_FINAL, DATA_W'(act_clamp)};
                n_result.status = STS_DONE;
            end
        end else begin
            case (kind)
                KIND_INNER: begin
                    n_bind_node     = data[NODE_W-1:0];
                    n_result.status = STS_CONTINUE;
                end
                KIND_FINAL: begin
                    n_result.status = STS_CONFLICT;
                    n_bind_node     = '0;
                    n_skip          = 1'b1;
                end
                default: begin
                    if (32'(r_free_node) < 32'(NODE_COUNT)) begin
                        wr_en           = 1'b1;
                        wr_data         = {KIND_INNER, DATA_W'(r_free_node[NODE_W-1:0])};
                        n_bind_node     = r_free_node[NODE_W-1:0];
                        n_free_node     = r_free_node + FREE_W'(1);
                        n_result.status = STS_CONTINUE;
                    end else begin
                        n_result.status = STS_EXHAUSTED;
                        n_bind_node     = '0;
                        n_skip          = 1'b1;
                    end
                end
            endcase
        end
    end

    // write port shared by the clearing pass and the step
    assign mem_waddr = i_cmd.clr_we ? r_clr_cnt : r_addr;
    assign mem_wdata = i_cmd.clr_we ? '0 : wr_data;

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we || (i_cmd.exec && wr_en)) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.load) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // request capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_req;
            r_addr <= rd_addr;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    // positions, free counter and clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_match_node <= '0;
            r_bind_node  <= '0;
            r_free_node  <= FREE_W'(1);
            r_skip       <= 1'b0;
        end else begin
            if (i_cmd.clr_we) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cmd.exec) begin
                r_match_node <= n_match_node;
                r_bind_node  <= n_bind_node;
                r_free_node  <= n_free_node;
                r_skip       <= n_skip;
            end
        end
    end

    assign o_sts.clr_last = (32'(r_clr_cnt) == 32'(DEPTH - 1));
    assign o_result       = r_result;

endmodule

// ===== rtl/kstm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kstm_checker
    import kstm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_result
);

    logic res_not_match;

    // strobed result that is not a match
    assign res_not_match = o_valid && (o_result.status != STS_MATCH);

    // a taken request blocks the next cycle
    `KSTM_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, start && !busy, busy)

    // every taken request gets its result once its exec state is through
    `KSTM_ASSERT(a_result_latency, i_clk, i_rst_n, (start && !busy) |-> ##2 o_valid)

    // action is zero unless the result is a match
    `KSTM_ASSERT(a_action_zero, i_clk, i_rst_n, res_not_match |-> (o_result.matched_action == 8'd0))

    // a result strobe lasts one cycle
    `KSTM_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

bind key_sequence_trie_matcher_top kstm_checker u_kstm_checker (.*);
